### rtl/gbs_pkg.sv
// Package for the grid binomial smoother: register map, configuration
// widths and the control word that travels with an item into the stencil.
// No dependencies.
package gbs_pkg;

   // Default sizes, handed to the top level as parameter defaults.
   localparam int DEF_MAX_COLS     = 1024;
   localparam int DEF_MAX_ROWS     = 1024;
   localparam int DEF_SAMPLE_WIDTH = 32;

   // Configuration port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam int CFG_W      = 11;

   localparam logic [CSR_IDX_W-1:0] REG_ROWS_USED = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_COLS_USED = CSR_IDX_W'(1);

   localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(1024);
   localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(1024);

   localparam int unsigned MIN_ROWS = 3;
   localparam int unsigned MIN_COLS = 2;

   // Per-item control decided at acceptance from the raster position.
   typedef struct packed {
      logic has_first;  // row above exists: a pass or smoothed word is due
      logic row_one;    // second row: first row passes through
      logic has_self;   // last row: the input itself goes out as well
      logic frame_end;  // last cell of the frame
      logic col_zero;   // first column of a row
      logic col_last;   // last column of a row
   } item_ctl_type;

endpackage

### rtl/gbs_req_if.sv
// Input channel of the grid binomial smoother: valid/ready plus one sample.
// Depends on nothing.
interface gbs_req_if #(parameter int SAMPLE_WIDTH = 32);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_value;

   modport source (output valid, output sample_value, input ready);
   modport sink   (input valid, input sample_value, output ready);
endinterface

### rtl/gbs_rsp_if.sv
// Result channel of the grid binomial smoother: valid/ready plus the
// smoothed word and its run and frame markers. Depends on nothing.
interface gbs_rsp_if #(parameter int SAMPLE_WIDTH = 32);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] smoothed_value;
   logic                           last_in_run;
   logic                           end_of_frame;

   modport source (output valid, output smoothed_value, output last_in_run,
                   output end_of_frame, input ready);
   modport sink   (input valid, input smoothed_value, input last_in_run,
                   input end_of_frame, output ready);
endinterface

### rtl/grid_binomial_smoother.sv
// Grid binomial smoother. Samples arrive in raster order and each interior
// row leaves as (4*centre + left + right + up + down)/8, floored, with the
// left and right neighbours wrapping around the row; the first and last
// rows pass through. Results trail the input by one row: an item in row i
// gives the word for row i-1 at its column, an item in the last row also
// gives itself back, and the first row gives nothing. One item is taken per
// clock while each item yields at most one word and the result channel is
// ready; in the last row each item yields two words through the single
// output register, so the next item waits for both. A word passes the
// stencil stage, then the output register. The two previous rows live in
// one store of 2*MAX_COLS samples with two read ports; it needs no clearing
// after reset. Writing either register restarts the frame at row 0. Depends
// on gbs_pkg, gbs_req_if, gbs_rsp_if, gbs_csr, gbs_row_mem and gbs_stencil.
module grid_binomial_smoother #(
   parameter int MAX_COLS     = gbs_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS     = gbs_pkg::DEF_MAX_ROWS,
   parameter int SAMPLE_WIDTH = gbs_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   gbs_req_if.sink                        req_chan,
   gbs_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [gbs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [gbs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [gbs_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import gbs_pkg::*;

   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int ADDR_W = COL_W + 1;

   logic [ROW_W-1:0]  rows_last;
   logic [COL_W-1:0]  cols_last;
   logic              restart;

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              row_last;
   logic              col_last;
   logic [COL_W-1:0]  col_next;
   logic              accept;
   logic              stage_ready;
   item_ctl_type      ctl;

   logic [ADDR_W-1:0]              up_addr;
   logic [ADDR_W-1:0]              above_addr;
   logic signed [SAMPLE_WIDTH-1:0] up_word;
   logic signed [SAMPLE_WIDTH-1:0] right_word;

   gbs_csr #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .rows_last (rows_last),
      .cols_last (cols_last),
      .restart   (restart)
   );

   assign req_chan.ready = stage_ready;
   assign accept         = req_chan.valid && stage_ready;

   assign row_last = (row_ff == rows_last);
   assign col_last = (col_ff == cols_last);
   assign col_next = col_last ? '0 : col_ff + COL_W'(1);

   always_comb begin
      col_in = col_next;
      row_in = row_ff;
      if (col_last) begin
         row_in = row_last ? '0 : row_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   always_comb begin
      ctl.has_first = (row_ff != '0);
      ctl.row_one   = (row_ff == ROW_W'(1));
      ctl.has_self  = row_last;
      ctl.frame_end = row_last && col_last;
      ctl.col_zero  = (col_ff == '0);
      ctl.col_last  = col_last;
   end

   // Rows alternate between the two halves by parity. Port A fetches the
   // row two above from the half about to be overwritten; port B fetches
   // the right neighbour in the row above, or the same column of it in row one.
   assign up_addr    = {row_ff[0], col_ff};
   assign above_addr = {~row_ff[0], ctl.row_one ? col_ff : col_next};

   gbs_row_mem #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .MAX_COLS     (MAX_COLS)
   ) u_row_mem (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (up_addr),
      .wr_data   (req_chan.sample_value),
      .rd_en     (accept),
      .rd_addr_a (up_addr),
      .rd_addr_b (above_addr),
      .rd_data_a (up_word),
      .rd_data_b (right_word)
   );

   gbs_stencil #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_stencil (
      .clock       (clock),
      .reset       (reset),
      .push        (accept),
      .push_ready  (stage_ready),
      .push_ctl    (ctl),
      .push_sample (req_chan.sample_value),
      .up_word     (up_word),
      .right_word  (right_word),
      .rsp_chan    (rsp_chan)
   );

endmodule

### rtl/gbs_csr.sv
// APB-style register block for the grid binomial smoother: holds rows_used
// and cols_used and their clamped last indexes. Depends on gbs_pkg.
module gbs_csr #(
   parameter int MAX_COLS = 1024,
   parameter int MAX_ROWS = 1024,
   localparam int COL_W = $clog2(MAX_COLS),
   localparam int ROW_W = $clog2(MAX_ROWS)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [gbs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [gbs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [gbs_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output logic [ROW_W-1:0]               rows_last,
   output logic [COL_W-1:0]               cols_last,
   output logic                           restart
);
   import gbs_pkg::*;

   localparam int unsigned ROWS_RST_NUM =
      (32'(ROWS_RESET) < MIN_ROWS) ? MIN_ROWS :
      (32'(ROWS_RESET) > MAX_ROWS) ? MAX_ROWS : 32'(ROWS_RESET);
   localparam int unsigned COLS_RST_NUM =
      (32'(COLS_RESET) < MIN_COLS) ? MIN_COLS :
      (32'(COLS_RESET) > MAX_COLS) ? MAX_COLS : 32'(COLS_RESET);

   logic [CFG_W-1:0]     rows_used_ff;
   logic [CFG_W-1:0]     cols_used_ff;
   logic [ROW_W-1:0]     rows_last_ff, rows_last_in;
   logic [COL_W-1:0]     cols_last_ff, cols_last_in;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_strobe;
   int unsigned          wr_num;
   int unsigned          rows_num;
   int unsigned          cols_num;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[CSR_ADDR_W-1:2];
   assign wr_strobe = psel && penable && pwrite;

   // The frame restarts at the same edge that writes the register.
   assign restart = wr_strobe &&
                    (reg_idx == REG_ROWS_USED || reg_idx == REG_COLS_USED);

   // Clamp the written value into the supported range at write time.
   always_comb begin
      wr_num   = 32'(pwdata[CFG_W-1:0]);
      rows_num = (wr_num < MIN_ROWS) ? MIN_ROWS :
                 (wr_num > MAX_ROWS) ? MAX_ROWS : wr_num;
      cols_num = (wr_num < MIN_COLS) ? MIN_COLS :
                 (wr_num > MAX_COLS) ? MAX_COLS : wr_num;
      rows_last_in = ROW_W'(rows_num - 1);
      cols_last_in = COL_W'(cols_num - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_used_ff <= ROWS_RESET;
         cols_used_ff <= COLS_RESET;
         rows_last_ff <= ROW_W'(ROWS_RST_NUM - 1);
         cols_last_ff <= COL_W'(COLS_RST_NUM - 1);
      end else begin
         if (wr_strobe) begin
            case (reg_idx)
               REG_ROWS_USED: begin
                  rows_used_ff <= pwdata[CFG_W-1:0];
                  rows_last_ff <= rows_last_in;
               end
               REG_COLS_USED: begin
                  cols_used_ff <= pwdata[CFG_W-1:0];
                  cols_last_ff <= cols_last_in;
               end
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      case (reg_idx)
         REG_ROWS_USED: prdata = CSR_DATA_W'(rows_used_ff);
         REG_COLS_USED: prdata = CSR_DATA_W'(cols_used_ff);
         default:       prdata = '0;
      endcase
   end

   assign rows_last = rows_last_ff;
   assign cols_last = cols_last_ff;

endmodule

### rtl/gbs_row_mem.sv
// Two-row sample store: one write port and two registered read ports.
// A read of the entry being written returns the old contents. Depends on
// gbs_pkg only through its callers.
module gbs_row_mem #(
   parameter int SAMPLE_WIDTH = 32,
   parameter int MAX_COLS = 1024,
   localparam int ADDR_W = $clog2(MAX_COLS) + 1
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  logic signed [SAMPLE_WIDTH-1:0] wr_data,
   input  logic                           rd_en,
   input  logic [ADDR_W-1:0]              rd_addr_a,
   input  logic [ADDR_W-1:0]              rd_addr_b,
   output logic signed [SAMPLE_WIDTH-1:0] rd_data_a,
   output logic signed [SAMPLE_WIDTH-1:0] rd_data_b
);
   localparam int DEPTH = 2 ** ADDR_W;

   logic signed [SAMPLE_WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

### rtl/gbs_stencil.sv
// Stencil stage and output register of the grid binomial smoother: takes
// the two words read from the row store, keeps a sliding window of the row
// above and emits up to two result words per item. Depends on gbs_pkg.
module gbs_stencil #(
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           push_ready,
   input  gbs_pkg::item_ctl_type          push_ctl,
   input  logic signed [SAMPLE_WIDTH-1:0] push_sample,
   input  logic signed [SAMPLE_WIDTH-1:0] up_word,
   input  logic signed [SAMPLE_WIDTH-1:0] right_word,
   gbs_rsp_if.source                      rsp_chan
);
   import gbs_pkg::*;

   localparam int SUM_W = SAMPLE_WIDTH + 3;

   // Stage holding the item whose memory words have just come back.
   logic                           s1_valid_ff;
   item_ctl_type                   s1_ctl_ff;
   logic signed [SAMPLE_WIDTH-1:0] s1_sample_ff;
   logic signed [SAMPLE_WIDTH-1:0] s1_edge_left_ff;
   logic signed [SAMPLE_WIDTH-1:0] s1_edge_centre_ff;
   logic                           pend_first_ff;
   logic                           pend_self_ff;

   // Window over the row above, and the end samples of the rows.
   logic signed [SAMPLE_WIDTH-1:0] win_left_ff;
   logic signed [SAMPLE_WIDTH-1:0] win_centre_ff;
   logic signed [SAMPLE_WIDTH-1:0] row_first_ff;
   logic signed [SAMPLE_WIDTH-1:0] prev_first_ff;
   logic signed [SAMPLE_WIDTH-1:0] prev_last_ff;

   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_value_ff;
   logic                           rsp_last_ff;
   logic                           rsp_eof_ff;

   logic signed [SAMPLE_WIDTH-1:0] left_use;
   logic signed [SAMPLE_WIDTH-1:0] centre_use;
   logic signed [SUM_W-1:0]        sum;
   logic signed [SAMPLE_WIDTH-1:0] first_value;
   logic signed [SAMPLE_WIDTH-1:0] emit_value;
   logic                           emit_pending;
   logic                           out_free;
   logic                           emit;
   logic                           emit_last;
   logic                           emit_eof;
   logic                           release_item;
   logic                           smooth;

   // At the first column the wrapped left neighbour and the centre come
   // from the end samples captured while the row above streamed in.
   assign left_use   = s1_ctl_ff.col_zero ? s1_edge_left_ff   : win_left_ff;
   assign centre_use = s1_ctl_ff.col_zero ? s1_edge_centre_ff : win_centre_ff;
   assign smooth     = s1_ctl_ff.has_first && !s1_ctl_ff.row_one;

   // Floor of the sum over eight is its top bits.
   assign sum = (SUM_W'(centre_use) <<< 2) + SUM_W'(left_use) + SUM_W'(right_word)
              + SUM_W'(up_word) + SUM_W'(s1_sample_ff);
   assign first_value = s1_ctl_ff.row_one ? right_word : sum[SUM_W-1:3];

   assign emit_pending = s1_valid_ff && (pend_first_ff || pend_self_ff);
   assign out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign emit         = emit_pending && out_free;
   assign emit_last    = pend_first_ff ? !pend_self_ff : 1'b1;
   assign emit_eof     = !pend_first_ff && s1_ctl_ff.frame_end;
   assign emit_value   = pend_first_ff ? first_value : s1_sample_ff;
   assign release_item = s1_valid_ff && (!emit_pending || (emit && emit_last));
   assign push_ready   = !s1_valid_ff || release_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         pend_first_ff <= 1'b0;
         pend_self_ff  <= 1'b0;
      end else if (push) begin
         s1_valid_ff   <= 1'b1;
         pend_first_ff <= push_ctl.has_first;
         pend_self_ff  <= push_ctl.has_self;
      end else begin
         if (emit) begin
            if (pend_first_ff) begin
               pend_first_ff <= 1'b0;
            end else begin
               pend_self_ff <= 1'b0;
            end
         end
         if (release_item) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         s1_ctl_ff    <= push_ctl;
         s1_sample_ff <= push_sample;
         if (push_ctl.col_zero) begin
            s1_edge_left_ff   <= prev_last_ff;
            s1_edge_centre_ff <= prev_first_ff;
            row_first_ff      <= push_sample;
         end
         if (push_ctl.col_last) begin
            prev_first_ff <= row_first_ff;
            prev_last_ff  <= push_sample;
         end
      end
      // The window slides once the smoothed word has used it.
      if (emit && pend_first_ff && smooth) begin
         win_left_ff   <= centre_use;
         win_centre_ff <= right_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_value_ff <= emit_value;
         rsp_last_ff  <= emit_last;
         rsp_eof_ff   <= emit_eof;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.smoothed_value = rsp_value_ff;
   assign rsp_chan.last_in_run    = rsp_last_ff;
   assign rsp_chan.end_of_frame   = rsp_eof_ff;

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for grid_binomial_smoother: raster streams under many
// frame sizes are checked word by word against a behavioral stencil model.
// Depends on gbs_pkg, gbs_req_if, gbs_rsp_if and the block itself.
module testbench;
   import gbs_pkg::*;

   localparam int SAMPLE_W       = DEF_SAMPLE_WIDTH;
   localparam int TOTAL_W        = SAMPLE_W + 4;
   localparam int GRID_COLS      = DEF_MAX_COLS;
   localparam int GRID_ROWS      = DEF_MAX_ROWS;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 650;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   localparam sample_type SAMPLE_MAX = 32'h7FFF_FFFF;
   localparam sample_type SAMPLE_MIN = 32'h8000_0000;

   typedef struct packed {
      sample_type smoothed_value;
      logic       last_in_run;
      logic       end_of_frame;
   } grid_word_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   gbs_req_if #(.SAMPLE_WIDTH(SAMPLE_W)) req_chan ();
   gbs_rsp_if #(.SAMPLE_WIDTH(SAMPLE_W)) rsp_chan ();

   grid_binomial_smoother dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Model state: two row halves, raster position and the frame size.
   sample_type       line_buffer [2*GRID_COLS];
   int unsigned      grid_row;
   int unsigned      grid_col;
   logic [CFG_W-1:0] rows_cfg;
   logic [CFG_W-1:0] cols_cfg;

   grid_word_type expected_words [$];
   sample_type    sample_queue [$];
   int            items_queued = 0;
   int            items_taken = 0;
   int            error_count = 0;
   int            watchdog_count = 0;
   logic          req_taken;
   logic          rsp_taken;
   int unsigned   send_gap;
   int unsigned   stall_left;
   logic          burst_mode;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned frame_rows();
      if (rows_cfg < MIN_ROWS) return MIN_ROWS;
      if (rows_cfg > GRID_ROWS) return GRID_ROWS;
      return 32'(rows_cfg);
   endfunction

   function automatic int unsigned row_cols();
      if (cols_cfg < MIN_COLS) return MIN_COLS;
      if (cols_cfg > GRID_COLS) return GRID_COLS;
      return 32'(cols_cfg);
   endfunction

   // Works out the words that one accepted sample releases and advances the
   // raster position.
   function automatic void smooth_sample(input sample_type sample);
      int unsigned               nrows;
      int unsigned               ncols;
      int unsigned               r;
      int unsigned               c;
      int unsigned               this_half;
      int unsigned               other_half;
      int unsigned               left_col;
      int unsigned               right_col;
      logic signed [TOTAL_W-1:0] total;
      grid_word_type             words [$];
      grid_word_type             word;
      nrows = frame_rows();
      ncols = row_cols();
      r = (grid_row >= nrows) ? 0 : grid_row;
      c = (grid_col >= ncols) ? 0 : grid_col;
      this_half = (r % 2) * GRID_COLS;
      other_half = GRID_COLS - this_half;
      left_col = (c == 0) ? ncols - 1 : c - 1;
      right_col = (c + 1 == ncols) ? 0 : c + 1;
      word = '0;
      if (r == 1) begin
         word.smoothed_value = line_buffer[other_half + c];
         words.push_back(word);
      end else if (r >= 2) begin
         // The row two above still sits in this half until the sample lands.
         total = (TOTAL_W'(line_buffer[other_half + c]) <<< 2)
               + TOTAL_W'(line_buffer[other_half + left_col])
               + TOTAL_W'(line_buffer[other_half + right_col])
               + TOTAL_W'(line_buffer[this_half + c]) + TOTAL_W'(sample);
         word.smoothed_value = sample_type'(total >>> 3);
         words.push_back(word);
      end
      line_buffer[this_half + c] = sample;
      if (r == nrows - 1) begin
         word.smoothed_value = sample;
         word.end_of_frame = (c == ncols - 1);
         words.push_back(word);
      end
      if (words.size() > 0) words[words.size()-1].last_in_run = 1'b1;
      foreach (words[i]) expected_words.push_back(words[i]);
      c++;
      if (c >= ncols) begin
         c = 0;
         r++;
         if (r >= nrows) r = 0;
      end
      grid_row = r;
      grid_col = c;
   endfunction

   function automatic int unsigned draw_gap();
      if (burst_mode || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 12);
   endfunction

   function automatic sample_type draw_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return sample_type'($urandom_range(0, 64)) - 32;
         default: return sample_type'($urandom());
      endcase
   endfunction

   task automatic queue_sample(input sample_type value);
      sample_queue.push_back(value);
      items_queued++;
   endtask

   // Waits until every sample is taken and every word is back, then lets the
   // pipeline empty of samples that release nothing.
   task automatic drain();
      while (items_taken != items_queued || expected_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input logic [CSR_IDX_W-1:0] index,
                             input logic [CFG_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      // Bits above the register width must be ignored.
      pwdata <= {(CSR_DATA_W-CFG_W)'($urandom()), value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (index == REG_ROWS_USED)
         rows_cfg = value;
      else
         cols_cfg = value;
      grid_row = 0;
      grid_col = 0;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   always @(negedge clock) begin : drive_samples
      int unsigned wait_cycles;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_chan.valid || req_taken) begin
         wait_cycles = req_taken ? draw_gap() : send_gap;
         if (wait_cycles == 0 && sample_queue.size() > 0) begin
            req_chan.valid <= 1'b1;
            req_chan.sample_value <= sample_queue.pop_front();
         end else begin
            req_chan.valid <= 1'b0;
            send_gap <= (wait_cycles > 0) ? wait_cycles - 1 : 0;
         end
      end
   end

   always @(negedge clock) begin : drive_ready
      int unsigned wait_cycles;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= 0;
      end else if (!rsp_chan.ready || rsp_taken) begin
         wait_cycles = rsp_taken ? draw_gap() : stall_left;
         rsp_chan.ready <= (wait_cycles == 0);
         stall_left <= (wait_cycles > 0) ? wait_cycles - 1 : 0;
      end
   end

   always @(posedge clock) begin : check_words
      grid_word_type seen;
      grid_word_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_chan.valid && req_chan.ready;
         rsp_taken <= rsp_chan.valid && rsp_chan.ready;
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen = '{rsp_chan.smoothed_value, rsp_chan.last_in_run, rsp_chan.end_of_frame};
            if (expected_words.size() == 0) begin
               $error("word with nothing expected: smoothed_value %0d", seen.smoothed_value);
               error_count++;
            end else begin
               want = expected_words.pop_front();
               if (seen.smoothed_value !== want.smoothed_value) begin
                  $error("smoothed_value: expected %0d, got %0d",
                         want.smoothed_value, seen.smoothed_value);
                  error_count++;
               end
               if (seen.last_in_run !== want.last_in_run) begin
                  $error("last_in_run: expected %0b, got %0b",
                         want.last_in_run, seen.last_in_run);
                  error_count++;
               end
               if (seen.end_of_frame !== want.end_of_frame) begin
                  $error("end_of_frame: expected %0b, got %0b",
                         want.end_of_frame, seen.end_of_frame);
                  error_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            items_taken++;
            smooth_sample(req_chan.sample_value);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         watchdog_count <= 0;
      else
         watchdog_count <= watchdog_count + 1;
      if (watchdog_count == WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned      random_items;
      int unsigned      count;
      int unsigned      cells;
      logic [1:0]       write_mask;
      logic [CFG_W-1:0] rows_pick;
      logic [CFG_W-1:0] cols_pick;
      sample_type       mixed_cells [9];
      mixed_cells = '{-1, 1, 0, SAMPLE_MAX, SAMPLE_MIN, -8, 7, -9, 32'h0001_0000};
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_chan.valid = 1'b0;
      req_chan.sample_value = '0;
      rsp_chan.ready = 1'b0;
      rows_cfg = ROWS_RESET;
      cols_cfg = COLS_RESET;
      grid_row = 0;
      grid_col = 0;
      burst_mode = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Reset sizes: the first row of a frame releases nothing.
      queue_sample(SAMPLE_MAX);
      queue_sample(SAMPLE_MIN);
      queue_sample(0);
      queue_sample(-1);
      drain();

      // Sizes below the minimum clamp to three rows of two; two whole frames
      // of the extreme values check the wrap back to row zero.
      write_size(REG_ROWS_USED, CFG_W'(0));
      write_size(REG_COLS_USED, CFG_W'(1));
      repeat (6) queue_sample(SAMPLE_MAX);
      repeat (6) queue_sample(SAMPLE_MIN);
      drain();

      write_size(REG_ROWS_USED, CFG_W'(3));
      write_size(REG_COLS_USED, CFG_W'(3));
      foreach (mixed_cells[i]) queue_sample(mixed_cells[i]);
      drain();

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         burst_mode = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 9))
            0: rows_pick = CFG_W'($urandom_range(0, 2));
            1: rows_pick = CFG_W'($urandom_range(GRID_ROWS, 2047));
            default: rows_pick = CFG_W'($urandom_range(3, 8));
         endcase
         case ($urandom_range(0, 11))
            0: cols_pick = CFG_W'($urandom_range(0, 1));
            1: cols_pick = CFG_W'($urandom_range(GRID_COLS, 2047));
            2: cols_pick = CFG_W'($urandom_range(10, 40));
            default: cols_pick = CFG_W'($urandom_range(2, 9));
         endcase
         // Without a write the frame simply carries on where it stopped.
         write_mask = 2'($urandom_range(0, 3));
         if (write_mask[0]) write_size(REG_ROWS_USED, rows_pick);
         if (write_mask[1]) write_size(REG_COLS_USED, cols_pick);
         cells = frame_rows() * row_cols();
         if (cells <= 90)
            count = cells * $urandom_range(1, 2) + $urandom_range(0, row_cols());
         else
            count = $urandom_range(1, 90);
         repeat (count) queue_sample(draw_sample());
         drain();
         random_items += count;
      end

      // Largest sizes: the first rows of a full-height frame, then the
      // start of a full-width row.
      burst_mode = 1'b0;
      write_size(REG_ROWS_USED, CFG_W'(GRID_ROWS));
      write_size(REG_COLS_USED, CFG_W'(0));
      repeat (60) queue_sample(draw_sample());
      drain();
      write_size(REG_ROWS_USED, CFG_W'(2));
      write_size(REG_COLS_USED, CFG_W'(2047));
      repeat (40) queue_sample(draw_sample());
      drain();
      write_size(REG_COLS_USED, CFG_W'(GRID_COLS));
      repeat (40) queue_sample(draw_sample());
      drain();

      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### files.f
rtl/gbs_pkg.sv
rtl/gbs_req_if.sv
rtl/gbs_rsp_if.sv
rtl/gbs_csr.sv
rtl/gbs_row_mem.sv
rtl/gbs_stencil.sv
rtl/grid_binomial_smoother.sv
bench/testbench.sv
